FILE: rtl/core/rgb_strip_hue_pattern_engine_core_assert.svh
// Assertion macros shared by the pattern engine core RTL.
`ifndef RGB_STRIP_HUE_PATTERN_ENGINE_CORE_ASSERT_SVH
`define RGB_STRIP_HUE_PATTERN_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RSHPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rshpe: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RSHPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rshpe: next-cycle check failed");

`endif

FILE: rtl/core/rshpe_pkg.sv
// Shared types, constants and color functions of the pattern engine core.
`timescale 1ns / 1ps
package rshpe_pkg;

    localparam int NUM_STRIPS   = 4;   // strips emitted per updating step
    localparam int STORE_STRIPS = 4;   // strips held in the channel store

    localparam logic [1:0] STRIP_LAST = 2'(NUM_STRIPS - 1);

    localparam logic [10:0] HUE_FULL = 11'd1530;
    localparam logic [10:0] HUE_SEG1 = 11'd255;
    localparam logic [10:0] HUE_SEG2 = 11'd510;
    localparam logic [10:0] HUE_SEG3 = 11'd765;
    localparam logic [10:0] HUE_SEG4 = 11'd1020;
    localparam logic [10:0] HUE_SEG5 = 11'd1275;

    localparam logic [2:0] MODE_SWEEP  = 3'd0;
    localparam logic [2:0] MODE_MULTI  = 3'd1;
    localparam logic [2:0] MODE_STROBE = 3'd2;
    localparam logic [2:0] MODE_BEAT   = 3'd3;
    localparam logic [2:0] MODE_PFADE  = 3'd4;
    localparam logic [2:0] MODE_HFADE  = 3'd5;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_TARGET = 2'd1;
    localparam logic [1:0] CFG_PHASE  = 2'd2;
    localparam logic [1:0] CFG_HALF   = 2'd3;

    localparam logic [2:0]  TGT_MAX        = 3'd4;
    localparam logic [15:0] HALF_RESET     = 16'd50000;
    localparam logic [7:0]  CH_RESET       = 8'd25;
    localparam logic [3:0]  PAL_FIRST      = 4'd1;
    localparam logic [3:0]  PAL_LAST       = 4'd8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef t_rgb [STORE_STRIPS-1:0] t_strips;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  target;
        logic [8:0]  phase_dist;
        logic [15:0] half;
    } t_cfg;

    typedef struct packed {
        logic        tick;
        logic        beat;
        logic [7:0]  level;
        logic [10:0] hue;
        logic        hue_valid;
    } t_item;

    typedef struct packed {
        t_strips     strips;
        logic [10:0] pos;
        logic [3:0]  pal;
        logic        phase;
        logic [15:0] cnt;
    } t_state;

    localparam t_rgb RGB_RESET = '{red: CH_RESET, green: CH_RESET, blue: CH_RESET};

    localparam t_rgb PALETTE [8] = '{
        '{red: 8'd255, green: 8'd255, blue: 8'd255},
        '{red: 8'd0,   green: 8'd255, blue: 8'd0},
        '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
        '{red: 8'd0,   green: 8'd255, blue: 8'd255},
        '{red: 8'd255, green: 8'd20,  blue: 8'd100},
        '{red: 8'd255, green: 8'd0,   blue: 8'd0},
        '{red: 8'd255, green: 8'd255, blue: 8'd0},
        '{red: 8'd255, green: 8'd0,   blue: 8'd255}
    };

    // Hue wheel, saturating above the full turn; all three channels set.
    function automatic t_rgb hue_to_rgb(input logic [11:0] t_in);
        logic [10:0] t;
        t_rgb        c;
        t = (t_in > {1'b0, HUE_FULL}) ? HUE_FULL : t_in[10:0];
        c = '0;
        priority if (t <= HUE_SEG1) begin
            c = '{red: 8'd255, green: t[7:0], blue: 8'd0};
        end else if (t <= HUE_SEG2) begin
            c = '{red: 8'(HUE_SEG2 - t), green: 8'd255, blue: 8'd0};
        end else if (t <= HUE_SEG3) begin
            c = '{red: 8'd0, green: 8'd255, blue: 8'(t - HUE_SEG2)};
        end else if (t <= HUE_SEG4) begin
            c = '{red: 8'd0, green: 8'(HUE_SEG4 - t), blue: 8'd255};
        end else if (t <= HUE_SEG5) begin
            c = '{red: 8'(t - HUE_SEG4), green: 8'd0, blue: 8'd255};
        end else begin
            c = '{red: 8'd255, green: 8'd0, blue: 8'(HUE_FULL - t)};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/rshpe_scale.sv
// Brightness scaler: each channel becomes channel * level / 255.
`timescale 1ns / 1ps
module rshpe_scale import rshpe_pkg::*; (
    input  t_rgb       i_color,
    input  logic [7:0] i_level,
    output t_rgb       o_color
);

    // x / 255 for x <= 255*255: estimate, then one compare-and-correct.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        logic [8:0]  q1;
        logic [16:0] prod;
        logic [16:0] rem;
        sum  = {1'b0, x} + 17'(x[15:8]);
        q1   = sum[16:8];
        prod = {q1, 8'd0} - 17'(q1);
        rem  = {1'b0, x} - prod;
        return (rem >= 17'd255) ? 8'(q1 + 9'd1) : q1[7:0];
    endfunction

    logic [15:0] w_r;
    logic [15:0] w_g;
    logic [15:0] w_b;

    assign w_r = 16'(i_color.red)   * 16'(i_level);
    assign w_g = 16'(i_color.green) * 16'(i_level);
    assign w_b = 16'(i_color.blue)  * 16'(i_level);

    assign o_color = '{red: div255(w_r), green: div255(w_g), blue: div255(w_b)};

endmodule

FILE: rtl/core/rshpe_step.sv
// Next-state logic for one step: pattern update of the store and counters.
`timescale 1ns / 1ps
module rshpe_step import rshpe_pkg::*; (
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  t_item  i_item,
    output t_state o_state,
    output logic   o_emit,
    output logic   o_done
);

    function automatic t_strips paint(input t_strips st, input logic [2:0] s, input t_rgb c);
        t_strips res;
        res = st;
        if (s == 3'd0) begin
            res = {STORE_STRIPS{c}};
        end else if (s <= TGT_MAX) begin
            res[2'(s - 3'd1)] = c;
        end
        return res;
    endfunction

    logic [1:0]  w_tgt_idx;
    t_rgb        w_cur_tgt;
    logic [11:0] w_hue_in;
    t_rgb        w_hue_col;
    logic        w_pal_ok;
    t_rgb        w_pal_col;
    logic [3:0]  w_pal_adv;
    t_rgb        w_scl_in;
    t_rgb        w_scl_out;
    logic [11:0] w_pd1;
    logic [11:0] w_pd2;
    logic [11:0] w_pd3;
    logic [11:0] w_t [4];
    t_rgb        w_multi [4];
    logic [16:0] w_cnt_inc;
    logic [16:0] w_hp;
    logic        w_toggle;
    logic [7:0]  w_strobe_v;

    assign w_tgt_idx = (i_cfg.target == 3'd0) ? 2'd0 : 2'(i_cfg.target - 3'd1);
    assign w_cur_tgt = i_state.strips[w_tgt_idx];

    // Sweep paints the incremented position, hue fade the input hue.
    assign w_hue_in  = (i_cfg.mode == MODE_SWEEP) ? (12'(i_state.pos) + 12'd1)
                                                  : {1'b0, i_item.hue};
    assign w_hue_col = hue_to_rgb(w_hue_in);

    assign w_pal_ok  = (i_state.pal >= PAL_FIRST) && (i_state.pal <= PAL_LAST);
    assign w_pal_col = PALETTE[3'(i_state.pal - PAL_FIRST)];
    assign w_pal_adv = (i_state.pal >= PAL_FIRST && i_state.pal < PAL_LAST)
                       ? (i_state.pal + 4'd1) : PAL_FIRST;

    always_comb begin
        if (i_cfg.mode == MODE_PFADE) begin
            w_scl_in = w_pal_ok ? w_pal_col : w_cur_tgt;
        end else begin
            w_scl_in = i_item.hue_valid ? w_hue_col : w_cur_tgt;
        end
    end

    rshpe_scale u_scale (
        .i_color (w_scl_in),
        .i_level (i_item.level),
        .o_color (w_scl_out)
    );

    // Four-strip sweep: per-strip offsets, wrapped once past the full turn.
    assign w_pd1 = 12'(i_cfg.phase_dist);
    assign w_pd2 = {w_pd1[10:0], 1'b0};
    assign w_pd3 = w_pd1 + w_pd2;

    always_comb begin
        logic [11:0] offs [4];
        offs[0] = 12'd0;
        offs[1] = w_pd1;
        offs[2] = w_pd2;
        offs[3] = w_pd3;
        for (int k = 0; k < 4; k++) begin
            w_t[k] = 12'(i_state.pos) + offs[k];
            if (w_t[k] > 12'(HUE_FULL)) begin
                w_t[k] = w_t[k] - 12'(HUE_FULL);
            end
            w_multi[k] = hue_to_rgb(w_t[k]);
        end
    end

    // Strobe counter; a zero half period acts as one.
    assign w_cnt_inc  = {1'b0, i_state.cnt} + 17'd1;
    assign w_hp       = (i_cfg.half == 16'd0) ? 17'd1 : {1'b0, i_cfg.half};
    assign w_toggle   = i_item.tick && (w_cnt_inc >= w_hp);
    assign w_strobe_v = (i_state.phase ^ w_toggle) ? 8'd255 : 8'd0;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_done  = 1'b0;
        unique case (i_cfg.mode)
            MODE_SWEEP, MODE_MULTI: begin
                if (i_state.pos >= HUE_FULL) begin
                    o_state.pos = 11'd0;
                    o_emit      = 1'b1;
                    o_done      = 1'b1;
                end else if (i_item.tick) begin
                    o_emit      = 1'b1;
                    o_state.pos = i_state.pos + 11'd1;
                    if (i_cfg.mode == MODE_SWEEP) begin
                        o_state.strips = paint(i_state.strips, i_cfg.target, w_hue_col);
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            o_state.strips[k] = w_multi[k];
                        end
                    end
                end
            end
            MODE_STROBE: begin
                if (i_item.tick) begin
                    o_state.cnt = w_toggle ? 16'd0 : w_cnt_inc[15:0];
                end
                o_state.phase     = i_state.phase ^ w_toggle;
                o_state.strips[0] = '{red: w_strobe_v, green: w_strobe_v, blue: w_strobe_v};
                if (w_toggle) begin
                    o_state.strips = {STORE_STRIPS{o_state.strips[0]}};
                    o_emit         = 1'b1;
                end
            end
            MODE_BEAT: begin
                if (w_pal_ok) begin
                    o_state.strips = paint(i_state.strips, i_cfg.target, w_pal_col);
                end
                if (i_item.beat) begin
                    o_state.pal    = w_pal_adv;
                    o_state.strips = {STORE_STRIPS{o_state.strips[0]}};
                    o_emit         = 1'b1;
                end
            end
            MODE_PFADE: begin
                o_state.strips = paint(i_state.strips, i_cfg.target, w_scl_out);
                if (i_item.beat) begin
                    o_state.pal = w_pal_adv;
                end
                o_emit = 1'b1;
            end
            MODE_HFADE: begin
                o_state.strips = paint(i_state.strips, i_cfg.target, w_scl_out);
                o_state.strips = {STORE_STRIPS{o_state.strips[0]}};
                o_emit         = 1'b1;
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/rshpe_emit.sv
// Result buffer: holds one snapshot of all strips and sends them in order.
`timescale 1ns / 1ps
`include "rgb_strip_hue_pattern_engine_core_assert.svh"
module rshpe_emit import rshpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_strips    i_strips,
    input  logic       i_done,
    input  logic       i_ready,
    output logic       o_free,
    output logic       o_valid,
    output logic [1:0] o_strip_number,
    output t_rgb       o_color,
    output logic       o_done,
    output logic       o_last
);

    logic       r_valid;
    logic       n_valid;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    t_strips    r_strips;
    logic       r_done;

    assign o_last = (r_idx == STRIP_LAST);
    assign o_free = !r_valid || (i_ready && o_last);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (r_valid && i_ready) begin
            n_valid = !o_last;
            n_idx   = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_strips <= i_strips;
            r_done   <= i_done;
        end
    end

    assign o_valid        = r_valid;
    assign o_strip_number = r_idx;
    assign o_color        = r_strips[r_idx];
    assign o_done         = r_done;

    `RSHPE_ASSERT_NXT(a_load_starts, i_clk, i_rst_n, i_load, o_valid && r_idx == 2'd0)
    `RSHPE_ASSERT_NXT(a_drain_ends, i_clk, i_rst_n, o_valid && i_ready && o_last && !i_load, !o_valid)

endmodule

FILE: rtl/core/rgb_strip_hue_pattern_engine_core.sv
// Top level of the RGB strip hue pattern engine core.
// The item is registered on transfer; when it commits, its results are loaded into
// the result buffer, and the buffer then offers them on the result channel.
// Throughput: one item per cycle when it makes no result; an updating step sends four
// strip results, one per cycle while i_out_ready is high; its item commits once the buffer is free.
// Reset (synchronous, active low): store all 25, sweep 0, palette 1, strobe cleared.
`timescale 1ns / 1ps
`include "rgb_strip_hue_pattern_engine_core_assert.svh"
module rgb_strip_hue_pattern_engine_core import rshpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_tick,
    input  logic        i_beat,
    input  logic [7:0]  i_level,
    input  logic [10:0] i_hue,
    input  logic        i_hue_valid,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_strip_number,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_sweep_done,
    output logic        o_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Input register: one pending item, refilled on the cycle it commits.
    logic   r_in_valid;
    logic   n_in_valid;
    t_item  r_item;

    // Pattern state and configuration.
    t_state r_st;
    t_state w_st_next;
    t_cfg   r_cfg;

    logic   w_emit;
    logic   w_done;
    logic   w_snap_free;
    logic   w_commit;
    logic   w_load;
    logic   w_in_xfer;
    t_rgb   w_color;

    // An item commits when its snapshot can go into the result buffer,
    // which may be emptied by the final result transfer this same cycle.
    assign w_commit  = r_in_valid && (!w_emit || w_snap_free);
    assign w_load    = w_commit && w_emit;
    assign o_in_ready = !r_in_valid || w_commit;
    assign w_in_xfer = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_xfer) begin
            n_in_valid = 1'b1;
        end else if (w_commit) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item <= '{tick: i_tick, beat: i_beat, level: i_level,
                        hue: i_hue, hue_valid: i_hue_valid};
        end
    end

    rshpe_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_st),
        .i_item  (r_item),
        .o_state (w_st_next),
        .o_emit  (w_emit),
        .o_done  (w_done)
    );

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.strips <= {STORE_STRIPS{RGB_RESET}};
            r_st.pos    <= 11'd0;
            r_st.pal    <= PAL_FIRST;
            r_st.phase  <= 1'b0;
            r_st.cnt    <= 16'd0;
        end else if (w_commit) begin
            r_st <= w_st_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_SWEEP, target: 3'd0, phase_dist: 9'd0, half: HALF_RESET};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_cfg.mode       <= i_cfg_data[2:0];
                CFG_TARGET: r_cfg.target     <= i_cfg_data[2:0];
                CFG_PHASE:  r_cfg.phase_dist <= i_cfg_data[8:0];
                CFG_HALF:   r_cfg.half       <= i_cfg_data;
                default:    r_cfg            <= r_cfg;
            endcase
        end
    end

    // Snapshot of the updated store, sent strip one first.
    rshpe_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_strips       (w_st_next.strips),
        .i_done         (w_done),
        .i_ready        (i_out_ready),
        .o_free         (w_snap_free),
        .o_valid        (o_out_valid),
        .o_strip_number (o_strip_number),
        .o_color        (w_color),
        .o_done         (o_sweep_done),
        .o_last         (o_last)
    );

    assign o_red   = w_color.red;
    assign o_green = w_color.green;
    assign o_blue  = w_color.blue;

    `RSHPE_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_st.pos <= HUE_FULL)
    `RSHPE_ASSERT_IMP(a_pal_range, i_clk, i_rst_n, 1'b1, r_st.pal >= PAL_FIRST && r_st.pal <= PAL_LAST)
    `RSHPE_ASSERT_IMP(a_load_room, i_clk, i_rst_n, w_load, w_snap_free)

endmodule
